// ----- hdl/ipv4_udp_checksum_verifier_defines.svh -----
// Assertion helpers shared by the checksum verifier modules.
`ifndef IPV4_UDP_CHECKSUM_VERIFIER_DEFINES_SVH
`define IPV4_UDP_CHECKSUM_VERIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPUC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checksum verifier assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPUC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checksum verifier assertion failed");

`endif

// ----- hdl/ipuc_pkg.sv -----
package ipuc_pkg;

  localparam int LINK_HEADER_BYTES = 14;
  localparam int IP_HEADER_BYTES   = 20;
  localparam int UPPER_START       = LINK_HEADER_BYTES + IP_HEADER_BYTES;
  localparam int UDP_HEADER_BYTES  = 8;

  // Byte offsets (within their header): the second byte of captured length words, and the first source-address byte.
  localparam logic [15:0] IP_TOTAL_LEN_OFS = 16'd3;
  localparam logic [15:0] IP_SRC_ADDR_OFS  = 16'd12;
  localparam logic [15:0] UDP_LEN_OFS      = 16'd5;

  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
  localparam logic [7:0]  PROTO_RESET  = 8'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ip_header_sum;
    logic [15:0] upper_layer_sum;
    logic        ip_header_ok;
    logic        upper_layer_ok;
    logic        packet_ok;
    logic [15:0] payload_length;
    logic        frame_short;
  } out_item_t;

  // Frame state captured on the last byte, handed to the result stage.
  typedef struct packed {
    logic [15:0] received;
    logic [15:0] ip_sum;
    logic [15:0] upper_sum;
    logic [7:0]  held_byte;
    logic [15:0] total_length;
    logic [15:0] udp_length;
  } frame_snap_t;

  // One's-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = 17'(a) + 17'(b);
    return s[15:0] + 16'(s[16]);
  endfunction

  // Three-operand one's-complement add; same result as two chained ones_add.
  function automatic logic [15:0] ones_add3(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
    logic [17:0] s;
    logic [16:0] t;
    s = 18'(a) + 18'(b) + 18'(c);
    t = 17'(s[15:0]) + 17'(s[17:16]);
    return t[15:0] + 16'(t[16]);
  endfunction

endpackage

// ----- hdl/ipuc_accum.sv -----
`include "ipv4_udp_checksum_verifier_defines.svh"

module ipuc_accum import ipuc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        snap_valid,
  input  logic        snap_ready,
  output frame_snap_t snap_data
);

  logic [15:0] byte_position_r, byte_position_nxt;
  logic [15:0] ip_sum_r, ip_sum_nxt;
  logic [15:0] upper_sum_r, upper_sum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] udp_len_r, udp_len_nxt;
  logic [7:0]  proto_r;
  logic        snap_valid_r;
  frame_snap_t snap_r;

  logic        in_acc;
  logic        last_acc;
  logic [15:0] ip_ofs, up_ofs, word;
  logic [16:0] end_pos;
  logic        in_ip, in_up;

  assign in_ready   = !snap_valid_r || snap_ready;
  assign in_acc     = in_valid && in_ready;
  assign last_acc   = in_acc && in_data.frame_end;
  assign snap_valid = snap_valid_r;
  assign snap_data  = snap_r;

  always_comb begin
    ip_ofs  = byte_position_r - 16'(LINK_HEADER_BYTES);
    up_ofs  = byte_position_r - 16'(UPPER_START);
    end_pos = 17'(LINK_HEADER_BYTES) + 17'(total_len_r);
    in_ip   = (byte_position_r >= 16'(LINK_HEADER_BYTES)) &&
              (byte_position_r < 16'(UPPER_START));
    in_up   = (byte_position_r >= 16'(UPPER_START)) && (17'(byte_position_r) < end_pos);
    word    = {held_r, in_data.data_byte};

    byte_position_nxt = byte_position_r;
    ip_sum_nxt        = ip_sum_r;
    upper_sum_nxt     = upper_sum_r;
    held_nxt          = held_r;
    total_len_nxt     = total_len_r;
    udp_len_nxt       = udp_len_r;

    // A saturated position counter freezes all per-frame state.
    if (byte_position_r != POS_MAX) begin
      if (in_ip) begin
        if (!ip_ofs[0]) begin
          held_nxt = in_data.data_byte;
        end else begin
          ip_sum_nxt = ones_add(ip_sum_r, word);
          if (ip_ofs == IP_TOTAL_LEN_OFS) begin
            total_len_nxt = word;
            upper_sum_nxt = ones_add3(upper_sum_r, word - 16'(IP_HEADER_BYTES),
                                      16'(proto_r));
          end else if (ip_ofs >= IP_SRC_ADDR_OFS) begin
            upper_sum_nxt = ones_add(upper_sum_r, word);
          end
        end
      end else if (in_up) begin
        if (!up_ofs[0]) begin
          held_nxt = in_data.data_byte;
        end else begin
          upper_sum_nxt = ones_add(upper_sum_r, word);
          if (up_ofs == UDP_LEN_OFS) begin
            udp_len_nxt = word;
          end
        end
      end
      byte_position_nxt = byte_position_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= '0;
      ip_sum_r        <= '0;
      upper_sum_r     <= '0;
      held_r          <= '0;
      total_len_r     <= '0;
      udp_len_r       <= '0;
      proto_r         <= PROTO_RESET;
      snap_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        proto_r <= cfg_wdata;
      end
      if (last_acc) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready) begin
        snap_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_data.frame_end) begin
          byte_position_r <= '0;
          ip_sum_r        <= '0;
          upper_sum_r     <= '0;
          held_r          <= '0;
          total_len_r     <= '0;
          udp_len_r       <= '0;
        end else begin
          byte_position_r <= byte_position_nxt;
          ip_sum_r        <= ip_sum_nxt;
          upper_sum_r     <= upper_sum_nxt;
          held_r          <= held_nxt;
          total_len_r     <= total_len_nxt;
          udp_len_r       <= udp_len_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_acc) begin
      snap_r.received     <= byte_position_nxt;
      snap_r.ip_sum       <= ip_sum_nxt;
      snap_r.upper_sum    <= upper_sum_nxt;
      snap_r.held_byte    <= held_nxt;
      snap_r.total_length <= total_len_nxt;
      snap_r.udp_length   <= udp_len_nxt;
    end
  end

  `IPUC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, last_acc, (byte_position_r == '0) && snap_valid_r)
  `IPUC_ASSERT_NEXT(a_pos_saturates, clk, rst_n, in_acc && (byte_position_r == POS_MAX), byte_position_r == POS_MAX || byte_position_r == '0)
  `IPUC_ASSERT_SAME(a_stall_when_full, clk, rst_n, !in_ready, snap_valid_r && !snap_ready)

endmodule

// ----- hdl/ipuc_finish.sv -----
`include "ipv4_udp_checksum_verifier_defines.svh"

module ipuc_finish import ipuc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  frame_snap_t snap_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam logic [16:0] START17 = 17'(UPPER_START);

  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res;
  logic [16:0] end_pos, rcv, upto;
  logic        odd_upper;
  logic [15:0] up_fold;

  assign snap_ready = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    end_pos   = 17'(LINK_HEADER_BYTES) + 17'(snap_data.total_length);
    rcv       = 17'(snap_data.received);
    upto      = (rcv < end_pos) ? rcv : end_pos;
    // An odd count of upper-layer bytes leaves a high byte waiting for padding.
    odd_upper = (upto > START17) && (upto[0] ^ START17[0]);
    up_fold   = odd_upper ? ones_add(snap_data.upper_sum, {snap_data.held_byte, 8'h00})
                          : snap_data.upper_sum;

    res.ip_header_sum   = (snap_data.ip_sum == '0) ? SUM_ALL_ONES : snap_data.ip_sum;
    res.upper_layer_sum = (up_fold == '0) ? SUM_ALL_ONES : up_fold;
    res.ip_header_ok    = res.ip_header_sum == SUM_ALL_ONES;
    res.upper_layer_ok  = res.upper_layer_sum == SUM_ALL_ONES;
    res.frame_short     = (snap_data.total_length < 16'(IP_HEADER_BYTES)) || (rcv < end_pos);
    res.packet_ok       = res.ip_header_ok && res.upper_layer_ok && !res.frame_short;
    res.payload_length  = (res.packet_ok && (snap_data.udp_length >= 16'(UDP_HEADER_BYTES)))
                        ? snap_data.udp_length - 16'(UDP_HEADER_BYTES) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      out_data_r <= res;
    end
  end

  `IPUC_ASSERT_NEXT(a_snap_moves_out, clk, rst_n, snap_valid && snap_ready, out_valid_r)
  `IPUC_ASSERT_SAME(a_len_needs_ok, clk, rst_n, out_valid_r && (out_data_r.payload_length != '0), out_data_r.packet_ok)
  `IPUC_ASSERT_SAME(a_ok_consistent, clk, rst_n, out_valid_r && out_data_r.packet_ok, out_data_r.ip_header_ok && out_data_r.upper_layer_ok && !out_data_r.frame_short)
  `IPUC_ASSERT_SAME(a_sum_nonzero, clk, rst_n, out_valid_r, (out_data_r.ip_header_sum != '0) && (out_data_r.upper_layer_sum != '0))

endmodule

// ----- hdl/ipv4_udp_checksum_verifier.sv -----
// Throughput: one frame byte per cycle while in_ready is high; no gaps between frames.
// Result path: the edge that takes the last byte captures the frame state in the snapshot
// register; the finish stage then forms the result and registers it for the consumer.
// Reset: synchronous, active-low rst_n clears all frame state and pending results
// and returns the protocol register to 17 (UDP).
// Backpressure on the result side stalls input only once both result stages hold data.

// The verifier walks a frame byte by byte. Bytes inside the IPv4 header feed the
// header checksum, while the total length, protocol register and addresses seed
// the pseudo-header sum that then takes the upper-layer bytes. The accumulator
// stage keeps the running sums and captures the frame state on the last byte;
// the finish stage pads an odd trailing byte, checks the sums and lengths, and
// holds the result transaction until the consumer takes it.
module ipv4_udp_checksum_verifier import ipuc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic        snap_valid;
  logic        snap_ready;
  frame_snap_t snap_data;

  // Running sums, length capture and the last-byte snapshot.
  ipuc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap_data (snap_data)
  );

  // Final fold, pass/fail flags and the registered result.
  ipuc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap_data (snap_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
